/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion helper macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pfau_pkg.sv */
// ----------------------------------------------------------------------------
// pfau_pkg
// widths, operation codes and types of the prime field arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package pfau_pkg;

  // operand and register widths
  localparam int OPW     = 32;
  localparam int CFG_W   = 32;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = $clog2(OPW);
  localparam int INV_W   = OPW + 8;
  localparam int IN_W    = 2 * OPW;

  // modulus after reset
  localparam logic [CFG_W-1:0] P_RESET = 32'hFFFF_FFFB;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_INV = 2'd3
  } mode_e;

  typedef logic [OPW-1:0]          word_t;
  typedef logic signed [INV_W-1:0] coef_t;

endpackage

`default_nettype wire

/* rtl/prime_field_arithmetic_unit_top.sv */
// One request first reduces operand a and then operand b (only a for an inverse),
// then runs its operation: add and subtract directly, multiply as one modular double
// and one conditional modular add per multiplier bit, inverse as a binary gcd loop
// followed by sign correction.
// One request at a time; the next is taken while the previous result waits.
// Reset clears control state and loads the modulus with 2^32 - 5.
// ----------------------------------------------------------------------------
// prime_field_arithmetic_unit_top
// modular add, subtract, multiply and inverse over a configured modulus,
// built around one shared modular adder and a binary extended gcd loop
// ----------------------------------------------------------------------------
`default_nettype none

module prime_field_arithmetic_unit_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // modulus write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfau_pkg::CFG_W-1:0]     cfg_data_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pfau_pkg::IN_W-1:0]      s_axis_tdata,  // operand_a, operand_b
  input  logic [pfau_pkg::MODE_W-1:0]    s_axis_tuser,  // mode
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pfau_pkg::OPW-1:0]       m_axis_tdata,  // field_result
  output logic                           m_axis_tuser   // no_inverse
);

  import pfau_pkg::*;

  `include "assert_macros.svh"

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RED_A    = 4'd1;
  localparam logic [3:0] ST_RED_B    = 4'd2;
  localparam logic [3:0] ST_ALU      = 4'd3;
  localparam logic [3:0] ST_MUL      = 4'd4;
  localparam logic [3:0] ST_INV_INIT = 4'd5;
  localparam logic [3:0] ST_INV      = 4'd6;
  localparam logic [3:0] ST_INV_FIX  = 4'd7;
  localparam logic [3:0] ST_DONE     = 4'd8;

  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(OPW - 1);

  // control registers
  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             m_valid_q, m_valid_d;
  word_t            p_q, p_d;

  // payload registers
  mode_e            mode_q, mode_d;
  word_t            a_q, a_d;
  word_t            b_q, b_d;
  word_t            acc_q, acc_d;
  logic             err_q, err_d;
  word_t            u_q, u_d;
  word_t            v_q, v_d;
  coef_t            ca_q, ca_d;
  coef_t            cb_q, cb_d;
  coef_t            cc_q, cc_d;
  coef_t            cd_q, cd_d;
  word_t            m_data_q, m_data_d;
  logic             m_user_q, m_user_d;

  // shared modular adder
  word_t            mu_x, mu_y;
  logic             mu_cin;
  logic [OPW:0]     mu_sum;
  logic [OPW:0]     mu_diff;
  word_t            mu_out;

  // gcd helpers
  coef_t            x_ext, p_ext;
  coef_t            ha_sum, hb_sum, hc_sum, hd_sum;
  word_t            sub_res;

  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // operand select for the shared modular adder
  always_comb begin
    mu_x   = acc_q;
    mu_y   = acc_q;
    mu_cin = 1'b0;
    case (state_q)
      ST_RED_A: mu_cin = a_q[cnt_q];
      ST_RED_B: mu_cin = b_q[cnt_q];
      ST_MUL: begin
        if (phase_q) begin
          mu_y = a_q;
        end
      end
      ST_ALU: begin
        mu_x = a_q;
        mu_y = b_q;
      end
      default: mu_cin = 1'b0;
    endcase
  end

  // x + y + cin, reduced once by p (inputs below p)
  assign mu_sum  = (OPW+1)'(mu_x) + (OPW+1)'(mu_y) + (OPW+1)'(mu_cin);
  assign mu_diff = mu_sum - (OPW+1)'(p_q);
  assign mu_out  = (mu_sum >= (OPW+1)'(p_q)) ? mu_diff[OPW-1:0] : mu_sum[OPW-1:0];

  // modular subtract, wraps back into range by adding p
  assign sub_res = (a_q >= b_q) ? (a_q - b_q) : (a_q - b_q + p_q);

  // signed views of the operand and modulus for the gcd loop
  assign x_ext  = signed'(INV_W'(a_q));
  assign p_ext  = signed'(INV_W'(p_q));
  assign ha_sum = ca_q + p_ext;
  assign hb_sum = cb_q - x_ext;
  assign hc_sum = cc_q + p_ext;
  assign hd_sum = cd_q - x_ext;

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    p_d       = p_q;
    mode_d    = mode_q;
    a_d       = a_q;
    b_d       = b_q;
    acc_d     = acc_q;
    err_d     = err_q;
    u_d       = u_q;
    v_d       = v_q;
    ca_d      = ca_q;
    cb_d      = cb_q;
    cc_d      = cc_q;
    cd_d      = cd_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_valid_d = m_valid_q && !m_axis_tready;

    // modulus write
    if (cfg_valid_i && cfg_ready_o) begin
      p_d = OPW'(cfg_data_i);
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          mode_d  = mode_e'(s_axis_tuser);
          a_d     = s_axis_tdata[OPW-1:0];
          b_d     = s_axis_tdata[IN_W-1:OPW];
          acc_d   = '0;
          err_d   = 1'b0;
          cnt_d   = CNT_TOP;
          phase_d = 1'b0;
          if (p_q == '0) begin
            // no modulus: zero result, inverse reports failure
            err_d   = (mode_e'(s_axis_tuser) == MODE_INV);
            state_d = ST_DONE;
          end else begin
            state_d = ST_RED_A;
          end
        end
      end

      // reduce operand a, one bit a cycle from the top
      ST_RED_A: begin
        acc_d = mu_out;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          a_d     = mu_out;
          acc_d   = '0;
          cnt_d   = CNT_TOP;
          state_d = (mode_q == MODE_INV) ? ST_INV_INIT : ST_RED_B;
        end
      end

      // reduce operand b
      ST_RED_B: begin
        acc_d = mu_out;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          b_d     = mu_out;
          acc_d   = '0;
          cnt_d   = CNT_TOP;
          phase_d = 1'b0;
          state_d = (mode_q == MODE_MUL) ? ST_MUL : ST_ALU;
        end
      end

      // add or subtract straight into the accumulator
      ST_ALU: begin
        acc_d   = (mode_q == MODE_ADD) ? mu_out : sub_res;
        state_d = ST_DONE;
      end

      // shift-add multiply: double, then add a when the bit of b is set
      ST_MUL: begin
        if (!phase_q) begin
          acc_d   = mu_out;
          phase_d = 1'b1;
        end else begin
          if (b_q[cnt_q]) begin
            acc_d = mu_out;
          end
          phase_d = 1'b0;
          if (cnt_q == '0) begin
            state_d = ST_DONE;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end

      // screen out cases with no inverse, load the gcd loop
      ST_INV_INIT: begin
        if ((p_q < OPW'(2)) || (a_q == '0) || (!a_q[0] && !p_q[0])) begin
          err_d   = 1'b1;
          acc_d   = '0;
          state_d = ST_DONE;
        end else begin
          u_d     = a_q;
          v_d     = p_q;
          ca_d    = coef_t'(1);
          cb_d    = '0;
          cc_d    = '0;
          cd_d    = coef_t'(1);
          state_d = ST_INV;
        end
      end

      // binary extended gcd, one step a cycle
      ST_INV: begin
        if (u_q == '0) begin
          if (v_q == OPW'(1)) begin
            state_d = ST_INV_FIX;
          end else begin
            err_d   = 1'b1;
            acc_d   = '0;
            state_d = ST_DONE;
          end
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
          if (!ca_q[0] && !cb_q[0]) begin
            ca_d = ca_q >>> 1;
            cb_d = cb_q >>> 1;
          end else begin
            ca_d = ha_sum >>> 1;
            cb_d = hb_sum >>> 1;
          end
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
          if (!cc_q[0] && !cd_q[0]) begin
            cc_d = cc_q >>> 1;
            cd_d = cd_q >>> 1;
          end else begin
            cc_d = hc_sum >>> 1;
            cd_d = hd_sum >>> 1;
          end
        end else if (u_q >= v_q) begin
          u_d  = u_q - v_q;
          ca_d = ca_q - cc_q;
          cb_d = cb_q - cd_q;
        end else begin
          v_d  = v_q - u_q;
          cc_d = cc_q - ca_q;
          cd_d = cd_q - cb_q;
        end
      end

      // bring the coefficient into 0..p-1
      ST_INV_FIX: begin
        if (cc_q < 0) begin
          cc_d = cc_q + p_ext;
        end else if (cc_q >= p_ext) begin
          cc_d = cc_q - p_ext;
        end else begin
          acc_d   = cc_q[OPW-1:0];
          state_d = ST_DONE;
        end
      end

      // hand over to the output register once it is free
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = acc_q;
          m_user_d  = err_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      phase_q   <= 1'b0;
      m_valid_q <= 1'b0;
      p_q       <= OPW'(P_RESET);
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      m_valid_q <= m_valid_d;
      p_q       <= p_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    err_q    <= err_d;
    u_q      <= u_d;
    v_q      <= v_d;
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    cc_q     <= cc_d;
    cd_q     <= cd_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // a failed inverse always carries a zero result
  `ASSERT_SAME(a_err_zero, m_valid_q && m_user_q, m_data_q == '0,
               "no_inverse set with non-zero result")

  // running residue stays below the modulus
  `ASSERT_SAME(a_acc_range,
               (state_q == ST_RED_A) || (state_q == ST_RED_B) || (state_q == ST_MUL),
               acc_q < p_q, "accumulator escaped the residue range")

  // one request at a time
  `ASSERT_NEXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready,
               "request accepted while busy")

endmodule

`default_nettype wire

/* bench/prime_field_arithmetic_unit_top_tb.sv */
// ----------------------------------------------------------------------------
// prime_field_arithmetic_unit_top_tb
// Self-checking bench for the modular arithmetic unit. A driver pushes add,
// subtract, multiply and inverse requests while a monitor takes the results.
// Each result is checked field by field against a local integer model. The
// run covers several moduli: the reset value, zero, one, two, small primes,
// composites, a power of two and random values. Both sides idle at random.
// ----------------------------------------------------------------------------
module prime_field_arithmetic_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfau_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 140;
  localparam int TAIL_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;

  typedef struct packed {
    mode_e op;
    word_t a;
    word_t b;
  } request_t;

  typedef struct packed {
    word_t value;
    logic  no_inv;
  } field_result_t;

  // dut ports, inputs known from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic [MODE_W-1:0] s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OPW-1:0]    m_axis_tdata;
  logic              m_axis_tuser;

  // bench state
  request_t      pending_requests[$];
  field_result_t expected_results[$];
  word_t         modulus      = P_RESET;
  bit            calm         = 1'b0;
  int            send_wait    = 0;
  int            recv_wait    = 0;
  int            error_count  = 0;
  int            cycle_count  = 0;
  request_t      next_req;
  field_result_t want;

  prime_field_arithmetic_unit_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // operand_a, operand_b
    .s_axis_tuser  (s_axis_tuser),  // mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // field_result
    .m_axis_tuser  (m_axis_tuser)   // no_inverse
  );

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // extended euclid, returns 0 when gcd(x, p) is not one
  function automatic bit mod_inverse(input logic [63:0] x, input logic [63:0] p,
                                     output logic [63:0] inv);
    longint r_prev, r_cur, t_prev, t_cur, q, tmp;
    r_prev = longint'(p);
    r_cur  = longint'(x);
    t_prev = 0;
    t_cur  = 1;
    inv    = '0;
    while (r_cur != 0) begin
      q      = r_prev / r_cur;
      tmp    = r_prev - q * r_cur;
      r_prev = r_cur;
      r_cur  = tmp;
      tmp    = t_prev - q * t_cur;
      t_prev = t_cur;
      t_cur  = tmp;
    end
    if (r_prev != 1) return 1'b0;
    if (t_prev < 0) t_prev = t_prev + longint'(p);
    inv = 64'(t_prev);
    return 1'b1;
  endfunction

  // expected result of one request under modulus p
  function automatic field_result_t field_op_result(mode_e op, word_t a_in, word_t b_in,
                                                    word_t p);
    field_result_t res;
    logic [63:0]   a, b, p64, inv;
    res = '0;
    p64 = {32'd0, p};
    // zero modulus: nothing to reduce by, inverse reports failure
    if (p == '0) begin
      res.no_inv = (op == MODE_INV);
      return res;
    end
    a = {32'd0, a_in} % p64;
    b = {32'd0, b_in} % p64;
    case (op)
      MODE_ADD: res.value = word_t'((a + b) % p64);
      MODE_SUB: res.value = word_t'((a >= b) ? a - b : a + p64 - b);
      MODE_MUL: res.value = word_t'((a * b) % p64);
      default: begin
        // modulus one, zero operand and shared factors all end here
        if (p64 >= 2 && mod_inverse(a, p64, inv)) res.value = word_t'(inv);
        else res.no_inv = 1'b1;
      end
    endcase
    return res;
  endfunction

  // operand biased towards the edges of the current modulus
  function automatic word_t pick_operand(word_t p);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return word_t'(1);
      2:       return p - 1;
      3:       return p;
      4:       return '1;
      5:       return (p != '0) ? word_t'($urandom % p) : word_t'($urandom);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic request_t make_request(mode_e op, word_t a, word_t b);
    request_t r;
    r.op = op;
    r.a  = a;
    r.b  = b;
    return r;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(field_op_result(mode_e'(s_axis_tuser),
                                                   s_axis_tdata[OPW-1:0],
                                                   s_axis_tdata[IN_W-1:OPW], modulus));
        send_wait = calm ? 0 : $urandom_range(0, 4);
      end
      // a request on the bus that is not yet taken stays as it is
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_wait != 0) begin
          send_wait = send_wait - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {next_req.b, next_req.a};
          s_axis_tuser  <= next_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got %h/%b", $time,
                   m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.value) begin
            error_count++;
            $display("%0t: field_result mismatch, expected %h, got %h", $time,
                     want.value, m_axis_tdata);
          end
          if (m_axis_tuser !== want.no_inv) begin
            error_count++;
            $display("%0t: no_inverse mismatch, expected %b, got %b", $time,
                     want.no_inv, m_axis_tuser);
          end
        end
        recv_wait = calm ? 0 : $urandom_range(0, 4);
      end
      if (recv_wait != 0) begin
        recv_wait = recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("prime_field_arithmetic_unit_top_tb NOT OK");
      $finish;
    end
  end

  // sender holds until every request has been answered
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  task automatic write_modulus(input word_t value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    modulus = value;
  endtask

  // stimulus
  initial begin
    word_t moduli[$];
    word_t p;
    int    k;
    p = P_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed edges under the reset modulus
    pending_requests.push_back(make_request(MODE_ADD, '0, '0));
    pending_requests.push_back(make_request(MODE_ADD, '1, '1));
    pending_requests.push_back(make_request(MODE_ADD, p - 1, 32'd1));
    pending_requests.push_back(make_request(MODE_ADD, p, p));
    pending_requests.push_back(make_request(MODE_SUB, '0, '0));
    pending_requests.push_back(make_request(MODE_SUB, '0, 32'd1));
    pending_requests.push_back(make_request(MODE_SUB, '1, '0));
    pending_requests.push_back(make_request(MODE_SUB, 32'd1, '1));
    pending_requests.push_back(make_request(MODE_MUL, '0, '1));
    pending_requests.push_back(make_request(MODE_MUL, '1, '1));
    pending_requests.push_back(make_request(MODE_MUL, p - 1, p - 1));
    pending_requests.push_back(make_request(MODE_MUL, 32'd1, p + 1));
    pending_requests.push_back(make_request(MODE_INV, '0, '0));
    pending_requests.push_back(make_request(MODE_INV, p, '1));
    pending_requests.push_back(make_request(MODE_INV, 32'd1, '0));
    pending_requests.push_back(make_request(MODE_INV, p - 1, '0));
    pending_requests.push_back(make_request(MODE_INV, '1, '0));
    pending_requests.push_back(make_request(MODE_INV, 32'd2, '1));
    pending_requests.push_back(make_request(MODE_INV, 32'h5555_5555, 32'hAAAA_AAAA));
    pending_requests.push_back(make_request(MODE_MUL, 32'hAAAA_AAAA, 32'h5555_5555));

    // moduli for the random phases, extremes and composites included
    moduli = {P_RESET, 32'd2, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd7, 32'd12,
              32'h7FFF_FFFF, 32'h0001_0000, 32'd0, 32'd0, P_RESET};
    moduli[9]  = word_t'($urandom_range(3, 1000));
    moduli[10] = word_t'($urandom) | 32'h8000_0001;

    foreach (moduli[i]) begin
      wait_drained();
      calm = (i % 4 == 2);
      if (i != 0) write_modulus(moduli[i]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pending_requests.push_back(make_request(mode_e'($urandom_range(0, 3)),
                                                pick_operand(modulus),
                                                pick_operand(modulus)));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("prime_field_arithmetic_unit_top_tb OK");
    end else begin
      $display("prime_field_arithmetic_unit_top_tb NOT OK");
    end
    $finish;
  end

endmodule
